/* hdl/bfrs_pkg.sv */
// shared types and constants for the bit field row store
// no dependencies; imported by the controller, datapath and top level
package bfrs_pkg;

  localparam int unsigned WordBitsC  = 64;
  localparam int unsigned WithinBitsC = 6;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } bfrs_cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_ACCESS,
    ST_UPPER,
    ST_WIPE,
    ST_REPLY
  } bfrs_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic access;
    logic upper;
    logic clr_step;
    logic clr_res;
    logic load_out;
  } bfrs_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic upper_wr;
    logic clr_last;
    logic out_free;
  } bfrs_stat_t;

endpackage

/* hdl/bfrs_ctrl.sv */
// sequencer for the bit field row store: capture, lookup, access, upper word write, reply, clear sweep
// depends on bfrs_pkg
module bfrs_ctrl
  import bfrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bfrs_stat_t stat_i,
  output bfrs_ctrl_t ctrl_o
);

  bfrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = stat_i.is_clear ? ST_WIPE : ST_ACCESS;
      end
      ST_ACCESS: begin
        state_d = stat_i.upper_wr ? ST_UPPER : ST_REPLY;
      end
      ST_UPPER: begin
        state_d = ST_REPLY;
      end
      ST_WIPE: begin
        if (stat_i.clr_last) state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctrl_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      ST_LOOK: begin
        ctrl_o.look = 1'b1;
      end
      ST_ACCESS: begin
        ctrl_o.access = 1'b1;
      end
      ST_UPPER: begin
        ctrl_o.upper = 1'b1;
      end
      ST_WIPE: begin
        ctrl_o.clr_step = 1'b1;
        ctrl_o.clr_res  = 1'b1;
      end
      ST_REPLY: begin
        ctrl_o.load_out = stat_i.out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

/* hdl/bfrs_datapath.sv */
// datapath for the bit field row store: item registers, bounds checks, word
// memory with two read ports, field extract and insert, output register
// depends on bfrs_pkg
module bfrs_datapath
  import bfrs_pkg::*;
#(
  parameter int unsigned ROW_BITS_MAX = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,
  input  logic [1:0]   cmd_i,
  input  logic [11:0]  slot_offset_i,
  input  logic [6:0]   field_width_i,
  input  logic [12:0]  slot_stride_i,
  input  logic [11:0]  element_i,
  input  logic [63:0]  write_value_i,
  input  bfrs_ctrl_t   ctrl_i,
  output bfrs_stat_t   stat_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  read_value_o,
  output logic         status_o
);

  localparam int unsigned RowWords = (ROW_BITS_MAX + WordBitsC - 1) / WordBitsC + 1;
  localparam int unsigned AddrW    = $clog2(RowWords);
  localparam logic [19:0] RowMaxC  = 20'(ROW_BITS_MAX);

  function automatic logic [63:0] width_mask(input logic [6:0] w);
    logic [63:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w) - 64'd1;
    end
    return m;
  endfunction

  logic [63:0] mem [RowWords];

  logic [12:0]  row_len_q;
  bfrs_cmd_e    cmd_q;
  logic [11:0]  off_q;
  logic [6:0]   w_q;
  logic [12:0]  stride_q;
  logic [11:0]  elem_q;
  logic [63:0]  wval_q;

  logic [AddrW-1:0] clr_cnt_q;
  logic [AddrW-1:0] idx_q;
  logic [5:0]       within_q;
  logic             ok_q;
  logic             straddle_q;
  logic [63:0]      lo_q, hi_q;

  logic [63:0] res_value_q;
  logic        res_status_q;
  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic        out_status_q;

  // lookup stage: position and checks from the captured item
  logic [18:0]      pos;
  logic [19:0]      run_end;
  logic [63:0]      mask_w;
  logic             ok;
  logic [AddrW-1:0] idx;
  logic [AddrW-1:0] idx_p1;

  always_comb begin
    pos     = 19'(off_q) + 19'(elem_q) * 19'(w_q);
    run_end = 20'(pos) + 20'(w_q);
    mask_w  = width_mask(w_q);
    ok      = (13'(elem_q) < stride_q) && (w_q <= 7'd64)
              && ((cmd_q == CMD_READ) || (cmd_q == CMD_WRITE))
              && ((cmd_q != CMD_WRITE) || ((wval_q & ~mask_w) == 64'd0))
              && (run_end <= 20'(row_len_q)) && (run_end <= RowMaxC);
    idx     = AddrW'(pos >> WithinBitsC);
    idx_p1  = AddrW'(idx_q + AddrW'(1));
  end

  // access stage: extract and insert over the two adjacent words
  logic [127:0] pair;
  logic [127:0] pair_sh;
  logic [127:0] m128;
  logic [127:0] v128;
  logic [63:0]  rd_field;
  logic [63:0]  new_lo;
  logic [63:0]  new_hi;
  logic         wr_ok;

  always_comb begin
    pair     = {hi_q, lo_q};
    pair_sh  = pair >> within_q;
    rd_field = pair_sh[63:0] & mask_w;
    m128     = {64'd0, mask_w} << within_q;
    v128     = {64'd0, wval_q & mask_w} << within_q;
    new_lo   = (lo_q & ~m128[63:0]) | v128[63:0];
    new_hi   = (hi_q & ~m128[127:64]) | v128[127:64];
    wr_ok    = ok_q && (cmd_q == CMD_WRITE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= '0;
    end else if (cfg_we_i) begin
      row_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= bfrs_cmd_e'(cmd_i);
      off_q    <= slot_offset_i;
      w_q      <= field_width_i;
      stride_q <= slot_stride_i;
      elem_q   <= element_i;
      wval_q   <= write_value_i;
    end
    if (ctrl_i.look) begin
      idx_q      <= idx;
      within_q   <= pos[5:0];
      ok_q       <= ok;
      straddle_q <= (7'(pos[5:0]) + w_q) > 7'd64;
    end
    if (ctrl_i.access) begin
      res_value_q  <= (ok_q && cmd_q == CMD_READ) ? rd_field : 64'd0;
      res_status_q <= !ok_q;
    end else if (ctrl_i.clr_res) begin
      res_value_q  <= 64'd0;
      res_status_q <= 1'b0;
    end
    if (ctrl_i.load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  // word memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_step) begin
      mem[clr_cnt_q] <= 64'd0;
    end else if (ctrl_i.access && wr_ok) begin
      mem[idx_q] <= new_lo;
    end else if (ctrl_i.upper) begin
      mem[idx_p1] <= new_hi;
    end
    if (ctrl_i.look) begin
      lo_q <= mem[idx];
      hi_q <= mem[AddrW'(idx + AddrW'(1))];
    end
  end

  // sweep counter parks at zero between clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : AddrW'(clr_cnt_q + AddrW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.is_clear = (cmd_q == CMD_CLEAR);
    stat_o.upper_wr = wr_ok && straddle_q;
    stat_o.clr_last = (clr_cnt_q == AddrW'(RowWords - 1));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;

endmodule

/* hdl/bit_field_row_store_top.sv */
// Bit field row store. Reads, writes or clears packed fields in a row of 64-bit
// words; element E of a column sits at slot_offset + E * field_width. A read or
// a non-straddling write passes through lookup, access and reply; a write
// that straddles two words adds an upper step (the single memory write port updates the
// second word in its own state), and a clear sweeps the row, zeroing one word
// per cycle over ROW_WORDS = ceil(ROW_BITS_MAX / 64) + 1 words.
// After reset the same sweep runs over all ROW_WORDS words (65 at the default)
// before the first input transfer is taken; row length writes belong between
// items, with nothing in flight.
// A finished result waits in the output register while the next item is taken.
// depends on bfrs_pkg, bfrs_ctrl and bfrs_datapath
module bit_field_row_store_top
  import bfrs_pkg::*;
#(
  parameter int unsigned ROW_BITS_MAX = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [12:0]  cfg_wdata_i,      // row length in bits
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // slot_offset[11:0], field_width[18:12], slot_stride[31:19], element[43:32],
  // write_value[107:44], zero fill above
  input  logic [111:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,   // cmd
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // read_value
  output logic         m_axis_tuser_o    // status
);

  bfrs_ctrl_t ctrl;
  bfrs_stat_t stat;

  bfrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  bfrs_datapath #(
    .ROW_BITS_MAX (ROW_BITS_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (s_axis_tuser_i),
    .slot_offset_i (s_axis_tdata_i[11:0]),
    .field_width_i (s_axis_tdata_i[18:12]),
    .slot_stride_i (s_axis_tdata_i[31:19]),
    .element_i     (s_axis_tdata_i[43:32]),
    .write_value_i (s_axis_tdata_i[107:44]),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .read_value_o  (m_axis_tdata_o),
    .status_o      (m_axis_tuser_o)
  );

endmodule
